/* src/rcwc_pkg.sv */
// Shared constants, types and the cosine table of the raycaster wall column pixel block.
package rcwc_pkg;

    // Block geometry
    localparam int SCREEN_HEIGHT   = 256;
    localparam int TILE_DIM        = 64;
    localparam int COS_TABLE_DEPTH = 256;

    // Field widths
    localparam int PD_W    = 12;
    localparam int DIST_W  = 24;
    localparam int ANGLE_W = 16;
    localparam int COORD_W = 16;
    localparam int ROW_W   = 8;
    localparam int TEX_W   = 6;

    // Derived widths
    localparam int TILE_LOG2 = $clog2(TILE_DIM);
    localparam int COS_IDX_W = $clog2(COS_TABLE_DEPTH);
    localparam int COS_W     = 16;                      // signed Q1.14
    localparam int CMAG_W    = 15;                      // 0 .. 16384
    localparam int COS_FRAC  = 14;
    localparam int NUM_W     = PD_W + TILE_LOG2 + 16;   // tile * pd * 65536
    localparam int NUM_SH    = TILE_LOG2 + 16;
    localparam int H_W       = 32;                      // height, Q24.8
    localparam int POS_W     = H_W + 2;                 // signed Q.9 positions
    localparam int DFT_W     = H_W - 8;
    localparam int TEXSH     = TILE_LOG2 + 8;
    localparam int T_W       = DFT_W + TEXSH;
    localparam int Q_W       = TILE_LOG2 + 1;
    localparam int SCR_LOG2  = $clog2(SCREEN_HEIGHT) + 1;
    localparam int Y_W       = (SCR_LOG2 > ROW_W + 1) ? SCR_LOG2 : ROW_W + 1;
    localparam int MID9      = (SCREEN_HEIGHT / 2) * 512;

    // Result source codes
    typedef enum logic [1:0] {
        SRC_CEILING = 2'd0,
        SRC_FLOOR   = 2'd1,
        SRC_WALL    = 2'd2
    } src_t;

    // Wall face codes
    typedef logic [1:0] face_t;
    localparam face_t FACE_EAST  = 2'd0;
    localparam face_t FACE_NORTH = 2'd1;
    localparam face_t FACE_SOUTH = 2'd2;
    localparam face_t FACE_WEST  = 2'd3;

    // Per-pixel values that ride along the pipeline
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             vert;
        logic             up;
        logic             down;
        logic             left;
        logic             right;
        logic [TEX_W-1:0] tx;
    } ctx_t;

    typedef logic [COS_TABLE_DEPTH-1:0][COS_W-1:0] cos_table_t;

    localparam longint unsigned Q28_ONE     = 64'd268435456;
    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

    // Shift-subtract unsigned quotient, elaboration only
    function automatic longint unsigned udiv_u64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = 0;
        r = 0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series of cos (odd = 0) or sin (odd = 1) in Q28, elaboration only
    function automatic longint taylor_q28(longint unsigned x, bit odd);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint          sum;
        int              n;
        x2   = (x * x) >> 28;
        term = odd ? x : Q28_ONE;
        sum  = longint'(term);
        for (n = 1; n <= 6; n++)
        begin
            d    = odd ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
            term = udiv_u64((term * x2) >> 28, d);
            if ((n & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return sum;
    endfunction

    // Cosine table over one turn, Q1.14, rounded half away from zero
    function automatic cos_table_t build_cos_table();
        cos_table_t      t;
        longint unsigned p;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint          v;
        longint          m;
        int              k;
        for (k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            p    = (longint'(k) << 16) >> COS_IDX_W;
            quad = (p >> 14) & 3;
            r    = p & 64'h3FFF;
            x    = (r * HALF_PI_Q28) >> 14;
            if (quad == 0)
                v = taylor_q28(x, 1'b0);
            else if (quad == 1)
                v = -taylor_q28(x, 1'b1);
            else if (quad == 2)
                v = -taylor_q28(x, 1'b0);
            else
                v = taylor_q28(x, 1'b1);
            m = (v < 0) ? -v : v;
            m = (m + 8192) >>> 14;
            if (m > 16384)
                m = 16384;
            t[k] = COS_W'((v < 0) ? -m : m);
        end
        return t;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

/* src/raycast_wall_column_pixel.sv */
// Raycaster wall column pixel: fish-eye fix, strip height, row class and texel address.
//
// One item per screen pixel enters on item_valid/item_ready and one result
// leaves on result_valid/result_ready for every item, in order.
// projection_distance is written by cfg_write/cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce; reset loads 277.
// The pipeline is 47 register stages deep: a cosine table read, a 24x15
// multiply, a 34-stage restoring divider for the strip height (one quotient
// bit per stage), height clamp, two stages of row geometry, a 7-stage divider
// for the texel row, and the output register. Throughput is one item per
// cycle while the output is not stalled; every stage advances together
// whenever the output register is empty or being taken.
// When the output register holds a result and result_ready is low, the
// whole pipeline freezes and item_ready drops in the same cycle; nothing
// is dropped or repeated. Reset clears all stage valid bits and the output
// valid; the block takes items from the first cycle after reset.
module raycast_wall_column_pixel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rcwc_pkg::PD_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [rcwc_pkg::DIST_W-1:0]   hit_distance,
    input  logic signed [rcwc_pkg::ANGLE_W-1:0] angle_delta,
    input  logic                          hit_vertical,
    input  logic [rcwc_pkg::COORD_W-1:0]  hit_coord,
    input  logic                          ray_up,
    input  logic                          ray_down,
    input  logic                          ray_left,
    input  logic                          ray_right,
    input  logic [rcwc_pkg::ROW_W-1:0]    row,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [1:0]                    source,
    output logic [1:0]                    face,
    output logic [rcwc_pkg::TEX_W-1:0]    tex_x,
    output logic [rcwc_pkg::TEX_W-1:0]    tex_y
);
    import rcwc_pkg::*;

    typedef struct packed {
        logic                    valid;
        ctx_t                    ctx;
        logic [DIST_W-1:0]       hdist;
        logic signed [COS_W-1:0] cosv;
    } sa_t;

    typedef struct packed {
        logic              valid;
        ctx_t              ctx;
        logic              neg;
        logic [DIST_W-1:0] corr;
        logic [DIST_W-1:0] rem;
        logic [NUM_W-1:0]  quot;
    } div_t;

    typedef struct packed {
        logic           valid;
        ctx_t           ctx;
        logic [H_W-1:0] h;
    } sh_t;

    typedef struct packed {
        logic             valid;
        ctx_t             ctx;
        logic [H_W-1:0]   h;
        logic [Y_W-1:0]   top;
        logic [Y_W-1:0]   bot;
        logic [DFT_W-1:0] dft;
        logic             found;
        face_t            face;
    } sw_t;

    typedef struct packed {
        logic             valid;
        logic             wall;
        src_t             base;
        face_t            face;
        logic [TEX_W-1:0] tx;
        logic [H_W-1:0]   h;
        logic [T_W-1:0]   rem;
        logic [Q_W-1:0]   q;
    } tq_t;

    localparam logic signed [POS_W-1:0] MID9_S   = POS_W'(MID9);
    localparam logic signed [POS_W-1:0] SCREEN_S = POS_W'(SCREEN_HEIGHT);

    logic                    en;
    logic [PD_W-1:0]         pd_reg;
    logic [NUM_W-1:0]        num_div;
    sa_t                     sa_reg;
    div_t                    div_reg [NUM_W+1];
    sh_t                     sh_reg;
    sw_t                     sw_reg;
    tq_t                     tq_reg [Q_W+1];
    logic                    out_valid_reg;
    src_t                    out_source_reg;
    face_t                   out_face_reg;
    logic [TEX_W-1:0]        out_tx_reg;
    logic [TEX_W-1:0]        out_ty_reg;

    logic [ANGLE_W+COS_IDX_W:0] idx_sum;
    logic [COS_IDX_W-1:0]       cos_idx;
    ctx_t                       in_ctx;
    logic [DIST_W+CMAG_W-1:0]   prod;
    logic                       h_sat;
    logic [H_W-1:0]             h_next;

    assign en         = !out_valid_reg || result_ready;
    assign item_ready = en;
    assign num_div    = {pd_reg, {NUM_SH{1'b0}}};

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pd_reg <= PD_W'(277);
        else if (cfg_write)
            pd_reg <= cfg_data;
    end

    // Stage A: cosine table index and read
    always_comb
    begin
        idx_sum      = {1'b0, angle_delta, {COS_IDX_W{1'b0}}} + (ANGLE_W+COS_IDX_W+1)'(32768);
        cos_idx      = idx_sum[ANGLE_W +: COS_IDX_W];
        in_ctx.row   = row;
        in_ctx.vert  = hit_vertical;
        in_ctx.up    = ray_up;
        in_ctx.down  = ray_down;
        in_ctx.left  = ray_left;
        in_ctx.right = ray_right;
        in_ctx.tx    = TEX_W'(hit_coord[TILE_LOG2-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_reg <= '0;
        else if (en)
        begin
            sa_reg.valid <= item_valid;
            sa_reg.ctx   <= in_ctx;
            sa_reg.hdist <= hit_distance;
            sa_reg.cosv  <= $signed(COS_TABLE[cos_idx]);
        end
    end

    // Stage B: corrected distance = hit distance * cos >> 14
    assign prod = sa_reg.hdist * CMAG_W'(sa_reg.cosv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reg[0] <= '0;
        else if (en)
        begin
            div_reg[0].valid <= sa_reg.valid;
            div_reg[0].ctx   <= sa_reg.ctx;
            div_reg[0].neg   <= sa_reg.cosv[COS_W-1];
            div_reg[0].corr  <= prod[COS_FRAC +: DIST_W];
            div_reg[0].rem   <= '0;
            div_reg[0].quot  <= '0;
        end
    end

    // Height divider: one restoring step per stage, numerator MSB first
    for (genvar g = 0; g < NUM_W; g++)
    begin : g_hdiv
        logic [DIST_W:0] rem_sh;
        logic            ge;
        div_t            dnext;

        always_comb
        begin
            rem_sh     = {div_reg[g].rem, num_div[NUM_W-1-g]};
            ge         = rem_sh >= {1'b0, div_reg[g].corr};
            dnext      = div_reg[g];
            dnext.rem  = ge ? DIST_W'(rem_sh - {1'b0, div_reg[g].corr}) : DIST_W'(rem_sh);
            dnext.quot = {div_reg[g].quot[NUM_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_reg[g+1] <= '0;
            else if (en)
                div_reg[g+1] <= dnext;
        end
    end

    // Height: empty for a negative cosine, saturated for zero distance or overflow
    always_comb
    begin
        h_sat = (div_reg[NUM_W].corr == '0) || (|div_reg[NUM_W].quot[NUM_W-1:H_W]);
        if (div_reg[NUM_W].neg)
            h_next = '0;
        else if (h_sat)
            h_next = '1;
        else
            h_next = div_reg[NUM_W].quot[H_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sh_reg <= '0;
        else if (en)
        begin
            sh_reg.valid <= div_reg[NUM_W].valid;
            sh_reg.ctx   <= div_reg[NUM_W].ctx;
            sh_reg.h     <= h_next;
        end
    end

    // Stage W1: strip top/bottom, distance from top, face
    logic signed [POS_W-1:0] hs;
    logic signed [POS_W-1:0] row_s;
    logic signed [POS_W-1:0] top9;
    logic signed [POS_W-1:0] bot9;
    logic signed [POS_W-1:0] d9;
    logic signed [POS_W-1:0] top_c;
    logic signed [POS_W-1:0] bot_c;
    logic                    found;
    face_t                   face_sel;

    always_comb
    begin
        hs    = $signed({2'b00, sh_reg.h});
        row_s = $signed({{(POS_W-ROW_W){1'b0}}, sh_reg.ctx.row});
        top9  = MID9_S - hs;
        top_c = top9[POS_W-1] ? '0 : (top9 >>> 9);
        bot9  = (MID9_S + hs) >>> 9;
        bot_c = (bot9 > SCREEN_S) ? SCREEN_S : bot9;
        d9    = (row_s <<< 9) + hs - MID9_S;
        // first matching flag wins
        found    = 1'b1;
        face_sel = FACE_EAST;
        if (sh_reg.ctx.vert && sh_reg.ctx.right)
            face_sel = FACE_WEST;
        else if (!sh_reg.ctx.vert && sh_reg.ctx.down)
            face_sel = FACE_SOUTH;
        else if (sh_reg.ctx.vert && sh_reg.ctx.left)
            face_sel = FACE_EAST;
        else if (!sh_reg.ctx.vert && sh_reg.ctx.up)
            face_sel = FACE_NORTH;
        else
            found = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sw_reg <= '0;
        else if (en)
        begin
            sw_reg.valid <= sh_reg.valid;
            sw_reg.ctx   <= sh_reg.ctx;
            sw_reg.h     <= sh_reg.h;
            sw_reg.top   <= Y_W'(top_c);
            sw_reg.bot   <= Y_W'(bot_c);
            sw_reg.dft   <= d9[POS_W-1] ? '0 : DFT_W'(d9 >>> 9);
            sw_reg.found <= found;
            sw_reg.face  <= face_sel;
        end
    end

    // Stage W2: wall test, texel-row numerator
    logic [Y_W-1:0] row_y;
    logic           in_strip;

    always_comb
    begin
        row_y    = Y_W'(sw_reg.ctx.row);
        in_strip = (sw_reg.h != '0) && (row_y >= sw_reg.top) && (row_y < sw_reg.bot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tq_reg[0] <= '0;
        else if (en)
        begin
            tq_reg[0].valid <= sw_reg.valid;
            tq_reg[0].wall  <= in_strip && sw_reg.found;
            tq_reg[0].base  <= (row_y < Y_W'(SCREEN_HEIGHT / 2)) ? SRC_CEILING : SRC_FLOOR;
            tq_reg[0].face  <= sw_reg.face;
            tq_reg[0].tx    <= sw_reg.ctx.tx;
            tq_reg[0].h     <= sw_reg.h;
            tq_reg[0].rem   <= {sw_reg.dft, {TEXSH{1'b0}}};
            tq_reg[0].q     <= '0;
        end
    end

    // Texel-row divider: top bit flags a quotient past the tile
    for (genvar g = 0; g < Q_W; g++)
    begin : g_tdiv
        logic [T_W-1:0] hsh;
        logic           ge;
        tq_t            tnext;

        always_comb
        begin
            hsh       = T_W'(tq_reg[g].h) << (Q_W - 1 - g);
            ge        = tq_reg[g].rem >= hsh;
            tnext     = tq_reg[g];
            tnext.rem = ge ? tq_reg[g].rem - hsh : tq_reg[g].rem;
            tnext.q   = {tq_reg[g].q[Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tq_reg[g+1] <= '0;
            else if (en)
                tq_reg[g+1] <= tnext;
        end
    end

    // Output register
    tq_t              tl;
    logic [TEX_W-1:0] ty_next;

    always_comb
    begin
        tl      = tq_reg[Q_W];
        ty_next = tl.q[Q_W-1] ? TEX_W'(TILE_DIM - 1) : TEX_W'(tl.q[Q_W-2:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_source_reg <= SRC_CEILING;
            out_face_reg   <= FACE_EAST;
            out_tx_reg     <= '0;
            out_ty_reg     <= '0;
        end
        else if (en)
        begin
            out_valid_reg  <= tl.valid;
            out_source_reg <= tl.wall ? SRC_WALL : tl.base;
            out_face_reg   <= tl.wall ? tl.face : FACE_EAST;
            out_tx_reg     <= tl.wall ? tl.tx : '0;
            out_ty_reg     <= tl.wall ? ty_next : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign source       = out_source_reg;
    assign face         = out_face_reg;
    assign tex_x        = out_tx_reg;
    assign tex_y        = out_ty_reg;

    // Non-wall results carry zero face and texel fields
    a_nonwall_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_source_reg != SRC_WALL) |->
        (out_face_reg == FACE_EAST && out_tx_reg == '0 && out_ty_reg == '0))
        else $error("non-wall result with nonzero texel fields");

    // A zero height never yields a wall pixel
    a_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
        (en && sw_reg.valid && sw_reg.h == '0) |=> !tq_reg[0].wall)
        else $error("wall pixel with zero strip height");

    // A negative cosine gives a zero height
    a_neg_cos: assert property (@(posedge clk) disable iff (!rst_n)
        (en && div_reg[NUM_W].valid && div_reg[NUM_W].neg) |=> (sh_reg.h == '0))
        else $error("negative cosine gave nonzero height");

    // The pipeline holds while the output is stalled
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(tq_reg[Q_W]) && $stable(sh_reg)))
        else $error("pipeline advanced during stall");

endmodule

/* test/tb_top.sv */
// Testbench for the raycaster wall column pixel block: directed table, then random pixels.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_PIXELS   = 290;
    localparam int NUM_PHASES     = 6;

    // One pixel request and one pixel result
    typedef struct {
        logic [DIST_W-1:0]         hdist;
        logic [ANGLE_W-1:0]        ang;
        logic                      vert;
        logic [COORD_W-1:0]        coord;
        logic                      up;
        logic                      down;
        logic                      left;
        logic                      right;
        logic [ROW_W-1:0]          row;
    } pixel_t;

    typedef struct {
        src_t              src;
        face_t             face;
        logic [TEX_W-1:0]  tx;
        logic [TEX_W-1:0]  ty;
    } texel_t;

    typedef struct {
        pixel_t  pix;
        bit      typed;
        texel_t  gold;
    } table_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [PD_W-1:0]     cfg_data;
    logic                item_valid;
    logic                item_ready;
    logic [DIST_W-1:0]   hit_distance;
    logic signed [ANGLE_W-1:0] angle_delta;
    logic                hit_vertical;
    logic [COORD_W-1:0]  hit_coord;
    logic                ray_up;
    logic                ray_down;
    logic                ray_left;
    logic                ray_right;
    logic [ROW_W-1:0]    row;
    logic                result_valid;
    logic                result_ready;
    logic [1:0]          source;
    logic [1:0]          face;
    logic [TEX_W-1:0]    tex_x;
    logic [TEX_W-1:0]    tex_y;

    raycast_wall_column_pixel dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .hit_distance (hit_distance),
        .angle_delta  (angle_delta),
        .hit_vertical (hit_vertical),
        .hit_coord    (hit_coord),
        .ray_up       (ray_up),
        .ray_down     (ray_down),
        .ray_left     (ray_left),
        .ray_right    (ray_right),
        .row          (row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .source       (source),
        .face         (face),
        .tex_x        (tex_x),
        .tex_y        (tex_y)
    );

    // Predictor state
    int              cos_q14 [COS_TABLE_DEPTH];
    longint unsigned proj_dist;
    texel_t          expected_texels [$];

    int  err_count;
    int  sent_count;
    int  got_count;
    int  idle_cnt;
    bit  tx_idle;
    bit  rx_idle;
    bit  hold_req;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Q28 series for cos (sine = 0) or sin (sine = 1) over the first quadrant
    function automatic longint trig_series(longint unsigned x, bit sine);
        longint unsigned sq;
        longint unsigned t;
        longint unsigned div;
        longint          acc;
        int              n;
        sq  = (x * x) >> 28;
        t   = sine ? x : 64'd268435456;
        acc = longint'(t);
        for (n = 1; n <= 6; n++)
        begin
            div = sine ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
            t   = ((t * sq) >> 28) / div;
            acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
        end
        return acc;
    endfunction

    // Fill the Q1.14 cosine table, round half away from zero
    function automatic void fill_cos_table();
        longint unsigned ph;
        longint unsigned x;
        longint          v;
        longint          mag;
        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            ph = (longint'(k) * 65536) / COS_TABLE_DEPTH;
            x  = ((ph & 64'h3FFF) * 64'd421657428) >> 14;
            case ((ph >> 14) & 3)
                0: v = trig_series(x, 1'b0);
                1: v = -trig_series(x, 1'b1);
                2: v = -trig_series(x, 1'b0);
                default: v = trig_series(x, 1'b1);
            endcase
            mag = (v < 0) ? -v : v;
            mag = (mag + 8192) >>> 14;
            if (mag > 16384)
                mag = 16384;
            cos_q14[k] = int'((v < 0) ? -mag : mag);
        end
    endfunction

    // Expected texel for one pixel under the current projection distance
    function automatic texel_t shade_pixel(pixel_t p);
        texel_t          r;
        longint unsigned idx;
        longint          c;
        longint unsigned corr;
        longint unsigned h;
        longint          mid9;
        longint          top9;
        longint          top;
        longint          bot;
        longint          rw;
        longint          d9;
        longint unsigned dft;
        longint unsigned v;
        bit              hit;
        face_t           f;
        mid9 = longint'(SCREEN_HEIGHT / 2) * 512;
        rw   = longint'(p.row);
        idx  = (longint'(p.ang) * COS_TABLE_DEPTH + 32768) >> 16;
        if (idx >= COS_TABLE_DEPTH)
            idx = idx - COS_TABLE_DEPTH;
        c = cos_q14[idx];
        if (c < 0)
            h = 0;
        else
        begin
            corr = (longint'(p.hdist) * c) >> 14;
            if (corr == 0)
                h = 64'hFFFF_FFFF;
            else
            begin
                h = (longint'(TILE_DIM) * proj_dist * 65536) / corr;
                if (h > 64'hFFFF_FFFF)
                    h = 64'hFFFF_FFFF;
            end
        end
        top9 = mid9 - longint'(h);
        top  = (top9 < 0) ? 0 : (top9 >>> 9);
        bot  = (mid9 + longint'(h)) >>> 9;
        if (bot > SCREEN_HEIGHT)
            bot = SCREEN_HEIGHT;

        r.src  = (rw < SCREEN_HEIGHT / 2) ? SRC_CEILING : SRC_FLOOR;
        r.face = FACE_EAST;
        r.tx   = '0;
        r.ty   = '0;
        hit    = 1'b0;
        f      = FACE_EAST;
        // Face priority: north, east, south, west; last match wins
        if (h != 0 && rw >= top && rw < bot)
        begin
            if (!p.vert && p.up)   begin hit = 1'b1; f = FACE_NORTH; end
            if (p.vert && p.left)  begin hit = 1'b1; f = FACE_EAST;  end
            if (!p.vert && p.down) begin hit = 1'b1; f = FACE_SOUTH; end
            if (p.vert && p.right) begin hit = 1'b1; f = FACE_WEST;  end
        end
        if (hit)
        begin
            d9  = rw * 512 + longint'(h) - mid9;
            dft = (d9 < 0) ? 0 : longint'(d9 >>> 9);
            v   = (dft * TILE_DIM * 256) / h;
            if (v > TILE_DIM - 1)
                v = TILE_DIM - 1;
            r.src  = SRC_WALL;
            r.face = f;
            r.tx   = TEX_W'(p.coord % TILE_DIM);
            r.ty   = TEX_W'(v);
        end
        return r;
    endfunction

    function automatic pixel_t mk_pixel(int hd, int ang, bit vert, int coord,
                                        bit up, bit down, bit left, bit right, int rw);
        pixel_t p;
        p.hdist = DIST_W'(hd);
        p.ang   = ANGLE_W'(ang);
        p.vert  = vert;
        p.coord = COORD_W'(coord);
        p.up    = up;
        p.down  = down;
        p.left  = left;
        p.right = right;
        p.row   = ROW_W'(rw);
        return p;
    endfunction

    function automatic texel_t mk_texel(src_t s);
        texel_t t;
        t.src  = s;
        t.face = FACE_EAST;
        t.tx   = '0;
        t.ty   = '0;
        return t;
    endfunction

    // Random pixel, weighted toward distances and angles that give visible walls
    function automatic pixel_t random_pixel();
        pixel_t p;
        p = mk_pixel(0, 0, $urandom_range(0, 1), $urandom_range(0, 65535),
                     $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       p.hdist = '0;
            1:       p.hdist = '1;
            2, 3, 4, 5: p.hdist = DIST_W'($urandom_range(64, 16384));
            6, 7:    p.hdist = DIST_W'($urandom_range(16384, 262144));
            default: p.hdist = DIST_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       p.ang = 16'h8000;
            1:       p.ang = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
            2, 3, 4, 5, 6: p.ang = ANGLE_W'(int'($urandom_range(0, 16384)) - 8192);
            default: p.ang = ANGLE_W'($urandom);
        endcase
        return p;
    endfunction

    // Offer one pixel, wait for it to be taken, then with tx_idle set sometimes drop item_valid for a random gap
    task automatic send_pixel(pixel_t p, bit typed, texel_t gold);
        hit_distance <= p.hdist;
        angle_delta  <= p.ang;
        hit_vertical <= p.vert;
        hit_coord    <= p.coord;
        ray_up       <= p.up;
        ray_down     <= p.down;
        ray_left     <= p.left;
        ray_right    <= p.right;
        row          <= p.row;
        item_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        expected_texels.push_back(typed ? gold : shade_pixel(p));
        sent_count++;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Write the projection distance once all results are back
    task automatic set_proj_dist(logic [PD_W-1:0] v);
        item_valid <= 1'b0;
        while (expected_texels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        proj_dist = longint'(v);
    endtask

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        texel_t e;
        if (rst_n && result_valid && result_ready)
        begin
            got_count++;
            if (expected_texels.size() == 0)
            begin
                $error("result with nothing expected: source %0d face %0d tex_x %0d tex_y %0d",
                       source, face, tex_x, tex_y);
                err_count++;
            end
            else
            begin
                e = expected_texels.pop_front();
                if (source !== e.src)
                begin
                    $error("source: expected %0d, got %0d", e.src, source);
                    err_count++;
                end
                if (face !== e.face)
                begin
                    $error("face: expected %0d, got %0d", e.face, face);
                    err_count++;
                end
                if (tex_x !== e.tx)
                begin
                    $error("tex_x: expected %0d, got %0d", e.tx, tex_x);
                    err_count++;
                end
                if (tex_y !== e.ty)
                begin
                    $error("tex_y: expected %0d, got %0d", e.ty, tex_y);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, expected_texels.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stall bursts plus one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        result_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_ready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial
    begin
        table_row_t      dir_rows [$];
        table_row_t      tr;
        texel_t          none;
        logic [PD_W-1:0] pd_list [NUM_PHASES];

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        hit_distance = '0;
        angle_delta  = '0;
        hit_vertical = 1'b0;
        hit_coord    = '0;
        ray_up       = 1'b0;
        ray_down     = 1'b0;
        ray_left     = 1'b0;
        ray_right    = 1'b0;
        row          = '0;
        err_count    = 0;
        sent_count   = 0;
        got_count    = 0;
        idle_cnt     = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_req     = 1'b0;
        none         = mk_texel(SRC_CEILING);

        fill_cos_table();
        proj_dist = 277;

        // Directed pixels; typed results where the answer is obvious
        tr.typed = 1'b1;
        tr.pix = mk_pixel(100, 16'h8000, 0, 5, 1, 1, 1, 1, 0);   tr.gold = mk_texel(SRC_CEILING);
        dir_rows.push_back(tr);
        tr.pix = mk_pixel(100, 16'h8000, 1, 5, 1, 1, 1, 1, 255); tr.gold = mk_texel(SRC_FLOOR);
        dir_rows.push_back(tr);
        tr.pix = mk_pixel(100, 16'h8001, 0, 7, 1, 0, 0, 0, 127); tr.gold = mk_texel(SRC_CEILING);
        dir_rows.push_back(tr);
        tr.pix = mk_pixel(0, 0, 0, 9, 0, 0, 0, 0, 10);           tr.gold = mk_texel(SRC_CEILING);
        dir_rows.push_back(tr);
        tr.pix = mk_pixel(0, 0, 1, 9, 1, 1, 0, 0, 200);          tr.gold = mk_texel(SRC_FLOOR);
        dir_rows.push_back(tr);
        tr.typed = 1'b0;
        tr.gold  = none;
        tr.pix = mk_pixel(0, 0, 0, 0, 1, 0, 0, 0, 0);                  dir_rows.push_back(tr);
        tr.pix = mk_pixel(0, 0, 1, 65535, 0, 0, 1, 0, 128);            dir_rows.push_back(tr);
        tr.pix = mk_pixel(24'hFFFFFF, 0, 0, 100, 0, 1, 0, 0, 128);     dir_rows.push_back(tr);
        tr.pix = mk_pixel(256, 0, 1, 65535, 0, 0, 0, 1, 127);          dir_rows.push_back(tr);
        tr.pix = mk_pixel(256, 16'h4000, 1, 33, 0, 0, 1, 1, 255);      dir_rows.push_back(tr);
        tr.pix = mk_pixel(512, 16'hC000, 0, 1, 1, 1, 1, 1, 0);         dir_rows.push_back(tr);
        tr.pix = mk_pixel(700, 16'h7FFF, 0, 2, 1, 0, 0, 0, 140);       dir_rows.push_back(tr);
        tr.pix = mk_pixel(300, 16'hFF80, 0, 3, 1, 0, 0, 0, 100);       dir_rows.push_back(tr);
        tr.pix = mk_pixel(1, 0, 0, 63, 1, 0, 0, 0, 127);               dir_rows.push_back(tr);
        tr.pix = mk_pixel(16'h4000, 0, 1, 16'h1234, 0, 0, 1, 0, 128);  dir_rows.push_back(tr);
        tr.pix = mk_pixel(16'h200, 0, 0, 64, 0, 1, 0, 0, 255);         dir_rows.push_back(tr);
        tr.pix = mk_pixel(16'h1000, 0, 0, 77, 1, 1, 0, 0, 64);         dir_rows.push_back(tr);
        tr.pix = mk_pixel(16'h400, 16'h1000, 1, 200, 0, 0, 1, 1, 150); dir_rows.push_back(tr);
        tr.pix = mk_pixel(16'h400, 16'hF000, 0, 65472, 1, 1, 1, 1, 90); dir_rows.push_back(tr);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].gold);

        // Random phases over several projection distances
        pd_list[0] = 12'd4095;
        pd_list[1] = 12'd1;
        pd_list[2] = PD_W'($urandom_range(2, 4094));
        pd_list[3] = 12'd277;
        pd_list[4] = PD_W'($urandom_range(2, 4094));
        pd_list[5] = 12'd2048;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_proj_dist(pd_list[ph]);
            if (ph == 2)
            begin
                // receiver holds off while the sender keeps pushing
                tx_idle  = 1'b0;
                hold_req = 1'b1;
            end
            else
                tx_idle = (ph != NUM_PHASES - 1) && (ph != 1);
            rx_idle = (ph != NUM_PHASES - 1);
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel(random_pixel(), 1'b0, none);
        end
        item_valid <= 1'b0;

        while (expected_texels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels (%0d directed) over %0d projection distances;",
                 sent_count, dir_rows.size(), NUM_PHASES + 1);
        $display("checked %0d results, %0d mismatches.", got_count, err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
